>>> rtl/core/i2c_hts_pkg.sv
`timescale 1ns / 1ps

package i2c_hts_pkg;

  // bus event codes
  typedef enum logic [1:0] {
    FuncConnect = 2'd0,
    FuncWrite   = 2'd1,
    FuncRead    = 2'd2
  } func_e;

  // progress through the measure command AC 33 00
  typedef enum logic [2:0] {
    ProgIdle   = 3'b001,
    ProgSawAc  = 3'b010,
    ProgSawCmd = 3'b100
  } prog_e;

  localparam int unsigned FrameLen = 7;
  localparam int unsigned PosW     = $clog2(FrameLen + 1);
  localparam int unsigned CodeW    = 20;
  localparam int unsigned HumW     = 14;
  localparam int unsigned TempW    = 15;

  localparam logic [7:0] CmdByte0   = 8'hAC;
  localparam logic [7:0] CmdByte1   = 8'h33;
  localparam logic [7:0] CmdByte2   = 8'h00;
  localparam logic [7:0] StatusByte = 8'h1C;
  localparam logic [7:0] NoDataByte = 8'hFF;
  localparam logic [7:0] CrcPoly    = 8'h31;
  localparam logic [7:0] CrcInit    = 8'hFF;

  localparam logic signed [TempW:0] TempOffset = (TempW + 1)'(5000);

  // ceil(2^40 / 625): x * 2^16 / 625 exact as (x * Recip) >> 24 for 14-bit x,
  // x * 2^15 / 625 exact as (x * Recip) >> 25 for 15-bit x
  localparam int unsigned RecipW = 31;
  localparam logic [RecipW-1:0] Recip = 31'd1759218605;

  typedef logic [CodeW-1:0] code_t;

  // bitwise CRC-8, MSB first, over six bytes
  function automatic logic [7:0] crc8_run(logic [7:0] init, logic [47:0] data);
    logic [7:0] crc;
    crc = init;
    for (int i = 47; i >= 0; i--) begin
      if (crc[7] ^ data[i]) begin
        crc = {crc[6:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // contribution of one set code bit; CRC is linear so columns simply xor
  function automatic logic [7:0] crc8_column(int unsigned bit_idx);
    return crc8_run(8'h00, 48'(1) << bit_idx);
  endfunction

  localparam logic [7:0] CrcBase = crc8_run(CrcInit, {StatusByte, 40'b0});

endpackage

>>> rtl/core/i2c_humidity_temperature_sensor_core.sv
`timescale 1ns / 1ps

// channel | handshake              | word
// --------+------------------------+------------------------------------------------
// in      | in_valid_i / in_stall_o | func_i, write_byte_i, humidity_centi_i,
//         |                        | temperature_centi_i
// out     | out_valid_o/out_stall_i | read_byte_o, ack_o
//
// One word per cycle sustained while out is not stalled; each word passes the input register, then the result register.
// The conversion multipliers and CRC network sit between those two registers.
// rst_ni clears the valid flags, command progress, read position and ready flag;
// the stored frame codes are undefined until the first measure command.
// A stall on out holds the result; in stalls only when both registers are full.
module i2c_humidity_temperature_sensor_core (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [1:0]                                func_i,
  input  logic [7:0]                                write_byte_i,
  input  logic [i2c_hts_pkg::HumW-1:0]              humidity_centi_i,
  input  logic signed [i2c_hts_pkg::TempW-1:0]      temperature_centi_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [7:0]                                read_byte_o,
  output logic                                      ack_o
);

  // input register
  logic                                 s1_valid_q;
  logic [1:0]                           s1_func_q;
  logic [7:0]                           s1_byte_q;
  logic [i2c_hts_pkg::HumW-1:0]         s1_hum_q;
  logic signed [i2c_hts_pkg::TempW-1:0] s1_temp_q;

  // result register
  logic       out_valid_q;
  logic [7:0] read_byte_q;

  // block state
  i2c_hts_pkg::prog_e             prog_q, prog_d;
  logic [i2c_hts_pkg::PosW-1:0]   read_pos_q, read_pos_d;
  logic                           ready_q, ready_d;
  i2c_hts_pkg::code_t             rh_q, tc_q;
  logic                           trigger;

  logic out_load, s1_adv;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_func_q <= func_i;
      s1_byte_q <= write_byte_i;
      s1_hum_q  <= humidity_centi_i;
      s1_temp_q <= temperature_centi_i;
    end
  end

  // conversion to 20-bit codes
  logic [i2c_hts_pkg::HumW+i2c_hts_pkg::RecipW-1:0]  rh_prod;
  logic [i2c_hts_pkg::TempW+i2c_hts_pkg::RecipW-1:0] tc_prod;
  logic signed [i2c_hts_pkg::TempW:0]                t_sum;
  logic [i2c_hts_pkg::CodeW:0]                       rh_raw, tc_raw;
  i2c_hts_pkg::code_t                                rh_new, tc_new;

  always_comb begin
    t_sum   = (i2c_hts_pkg::TempW + 1)'(s1_temp_q) + i2c_hts_pkg::TempOffset;
    rh_prod = (i2c_hts_pkg::HumW + i2c_hts_pkg::RecipW)'(s1_hum_q)
              * (i2c_hts_pkg::HumW + i2c_hts_pkg::RecipW)'(i2c_hts_pkg::Recip);
    tc_prod = (i2c_hts_pkg::TempW + i2c_hts_pkg::RecipW)'(t_sum[i2c_hts_pkg::TempW-1:0])
              * (i2c_hts_pkg::TempW + i2c_hts_pkg::RecipW)'(i2c_hts_pkg::Recip);
    rh_raw  = rh_prod[44:24];
    tc_raw  = tc_prod[45:25];
    rh_new  = rh_raw[i2c_hts_pkg::CodeW] ? '1 : rh_raw[i2c_hts_pkg::CodeW-1:0];
    if (t_sum[i2c_hts_pkg::TempW]) begin
      tc_new = '0;
    end else begin
      tc_new = tc_raw[i2c_hts_pkg::CodeW] ? '1 : tc_raw[i2c_hts_pkg::CodeW-1:0];
    end
  end

  // frame bytes from the stored codes
  logic [2*i2c_hts_pkg::CodeW-1:0] codes;
  logic [7:0] crc;
  logic [7:0] frame_byte;

  assign codes = {rh_q, tc_q};

  always_comb begin
    crc = i2c_hts_pkg::CrcBase;
    for (int unsigned i = 0; i < 2 * i2c_hts_pkg::CodeW; i++) begin
      if (codes[i]) begin
        crc = crc ^ i2c_hts_pkg::crc8_column(i);
      end
    end
  end

  always_comb begin
    case (read_pos_q)
      3'd0:    frame_byte = i2c_hts_pkg::StatusByte;
      3'd1:    frame_byte = rh_q[19:12];
      3'd2:    frame_byte = rh_q[11:4];
      3'd3:    frame_byte = {rh_q[3:0], tc_q[19:16]};
      3'd4:    frame_byte = tc_q[15:8];
      3'd5:    frame_byte = tc_q[7:0];
      3'd6:    frame_byte = crc;
      default: frame_byte = 8'h00;
    endcase
  end

  // event handling
  logic [7:0] result;

  always_comb begin
    prog_d     = prog_q;
    read_pos_d = read_pos_q;
    ready_d    = ready_q;
    trigger    = 1'b0;
    result     = 8'h00;
    unique case (s1_func_q)
      i2c_hts_pkg::FuncConnect: begin
        prog_d     = i2c_hts_pkg::ProgIdle;
        read_pos_d = '0;
      end
      i2c_hts_pkg::FuncWrite: begin
        unique case (prog_q)
          i2c_hts_pkg::ProgIdle: begin
            if (s1_byte_q == i2c_hts_pkg::CmdByte0) begin
              prog_d = i2c_hts_pkg::ProgSawAc;
            end
          end
          i2c_hts_pkg::ProgSawAc: begin
            prog_d = (s1_byte_q == i2c_hts_pkg::CmdByte1) ? i2c_hts_pkg::ProgSawCmd
                                                          : i2c_hts_pkg::ProgIdle;
          end
          i2c_hts_pkg::ProgSawCmd: begin
            if (s1_byte_q == i2c_hts_pkg::CmdByte2) begin
              trigger = 1'b1;
              ready_d = 1'b1;
            end
          end
          default: prog_d = i2c_hts_pkg::ProgIdle;
        endcase
      end
      i2c_hts_pkg::FuncRead: begin
        if (!ready_q) begin
          result = i2c_hts_pkg::NoDataByte;
        end else begin
          result = frame_byte;
          if (read_pos_q >= i2c_hts_pkg::PosW'(i2c_hts_pkg::FrameLen - 1)) begin
            ready_d = 1'b0;
          end
          if (read_pos_q < i2c_hts_pkg::PosW'(i2c_hts_pkg::FrameLen)) begin
            read_pos_d = read_pos_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q      <= i2c_hts_pkg::ProgIdle;
      read_pos_q  <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        prog_q     <= prog_d;
        read_pos_q <= read_pos_d;
        ready_q    <= ready_d;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && trigger) begin
      rh_q <= rh_new;
      tc_q <= tc_new;
    end
    if (s1_adv) begin
      read_byte_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = read_byte_q;
  assign ack_o       = 1'b1;

`ifndef SYNTH
  // last frame byte read drops the ready flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_func_q == i2c_hts_pkg::FuncRead && ready_q && read_pos_q >= 3'd6
    |=> !ready_q)
    else $error("ready flag survived end of frame");

  // a read with no measurement returns the no-data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_func_q == i2c_hts_pkg::FuncRead && !ready_q
    |=> out_valid_q && read_byte_q == i2c_hts_pkg::NoDataByte)
    else $error("read without measurement not 0xFF");

  // connect rewinds command and read position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_func_q == i2c_hts_pkg::FuncConnect
    |=> read_pos_q == '0 && prog_q == i2c_hts_pkg::ProgIdle)
    else $error("connect did not rewind");

  // read position only moves forward between connects
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_func_q != i2c_hts_pkg::FuncConnect
    |=> read_pos_q >= $past(read_pos_q))
    else $error("read position went backwards");
`endif

endmodule

>>> test/i2c_humidity_temperature_sensor_core_tb.sv
`timescale 1ns / 1ps

module i2c_humidity_temperature_sensor_core_tb;

  localparam logic [1:0] FuncSpare  = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         WordTarget = 1750;

  // expected bytes of the sensor, one per bus event
  class sensor_scoreboard;
    i2c_hts_pkg::prog_e cmd_step;
    logic [2:0]         rd_pos;
    logic               frame_ready;
    logic [7:0]         frame[i2c_hts_pkg::FrameLen];
    logic [7:0]         byte_q[$];
    int unsigned        errors;

    function new();
      cmd_step    = i2c_hts_pkg::ProgIdle;
      rd_pos      = '0;
      frame_ready = 1'b0;
      errors      = 0;
    endfunction

    function automatic logic [7:0] frame_crc();
      logic [7:0] crc;
      crc = i2c_hts_pkg::CrcInit;
      for (int i = 0; i < i2c_hts_pkg::FrameLen - 1; i++) begin
        crc ^= frame[i];
        for (int b = 0; b < 8; b++) begin
          crc = crc[7] ? ({crc[6:0], 1'b0} ^ i2c_hts_pkg::CrcPoly) : {crc[6:0], 1'b0};
        end
      end
      return crc;
    endfunction

    function void capture(logic [i2c_hts_pkg::HumW-1:0] hum,
                          logic signed [i2c_hts_pkg::TempW-1:0] temp);
      longint unsigned rh;
      longint unsigned tc;
      longint          t;
      rh = (longint'(hum) << 20) / 10000;
      t  = longint'(temp) + 5000;
      tc = (t < 0) ? 0 : ((t << 20) / 20000);
      if (rh > 1048575) rh = 1048575;
      if (tc > 1048575) tc = 1048575;
      frame[0] = i2c_hts_pkg::StatusByte;
      frame[1] = rh[19:12];
      frame[2] = rh[11:4];
      frame[3] = {rh[3:0], tc[19:16]};
      frame[4] = tc[15:8];
      frame[5] = tc[7:0];
      frame[6] = frame_crc();
    endfunction

    function void note_word(logic [1:0] f, logic [7:0] wb,
                            logic [i2c_hts_pkg::HumW-1:0] hum,
                            logic signed [i2c_hts_pkg::TempW-1:0] temp);
      logic [7:0] rb;
      rb = 8'h00;
      case (f)
        i2c_hts_pkg::FuncConnect: begin
          cmd_step = i2c_hts_pkg::ProgIdle;
          rd_pos   = '0;
        end
        i2c_hts_pkg::FuncWrite: begin
          case (cmd_step)
            i2c_hts_pkg::ProgIdle: begin
              if (wb == i2c_hts_pkg::CmdByte0) cmd_step = i2c_hts_pkg::ProgSawAc;
            end
            i2c_hts_pkg::ProgSawAc: begin
              cmd_step = (wb == i2c_hts_pkg::CmdByte1) ? i2c_hts_pkg::ProgSawCmd
                                                       : i2c_hts_pkg::ProgIdle;
            end
            i2c_hts_pkg::ProgSawCmd: begin
              if (wb == i2c_hts_pkg::CmdByte2) begin
                frame_ready = 1'b1;
                capture(hum, temp);
              end
            end
            default: cmd_step = i2c_hts_pkg::ProgIdle;
          endcase
        end
        i2c_hts_pkg::FuncRead: begin
          if (!frame_ready) begin
            rb = i2c_hts_pkg::NoDataByte;
          end else begin
            if (rd_pos < i2c_hts_pkg::FrameLen) rb = frame[rd_pos];
            if (rd_pos >= i2c_hts_pkg::FrameLen - 1) frame_ready = 1'b0;
            if (rd_pos < 7) rd_pos++;
          end
        end
        default: ;
      endcase
      byte_q.push_back(rb);
    endfunction

    function void check_word(logic [7:0] rb, logic ak);
      logic [7:0] exp_byte;
      if (byte_q.size() == 0) begin
        $error("read_byte: word with nothing expected, actual %02h", rb);
        errors++;
        return;
      end
      exp_byte = byte_q.pop_front();
      if (rb !== exp_byte) begin
        $error("read_byte: expected %02h, actual %02h", exp_byte, rb);
        errors++;
      end
      if (ak !== 1'b1) begin
        $error("ack: expected 1, actual %b", ak);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic [1:0]                           func_i = i2c_hts_pkg::FuncConnect;
  logic [7:0]                           write_byte_i = 8'h00;
  logic [i2c_hts_pkg::HumW-1:0]         humidity_centi_i = '0;
  logic signed [i2c_hts_pkg::TempW-1:0] temperature_centi_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic [7:0]                           read_byte_o;
  logic                                 ack_o;

  i2c_humidity_temperature_sensor_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .write_byte_i,
    .humidity_centi_i,
    .temperature_centi_i,
    .out_valid_o,
    .out_stall_i,
    .read_byte_o,
    .ack_o
  );

  sensor_scoreboard sensor_sb = new();

  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("i2c_humidity_temperature_sensor_core: mismatch");
      $finish;
    end
  end

  // receiver back-pressure: the stall mode is re-picked at random whenever its countdown runs out
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= (cycles[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sensor_sb.check_word(read_byte_o, ack_o);
  end

  function automatic logic [i2c_hts_pkg::HumW-1:0] rand_hum();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 14'd0;
        1: return 14'd1;
        2: return 14'd9999;
        default: return 14'd10000;
      endcase
    end
    return i2c_hts_pkg::HumW'($urandom_range(0, 10000));
  endfunction

  function automatic logic signed [i2c_hts_pkg::TempW-1:0] rand_temp();
    int v;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: v = -5000;
        1: v = -4999;
        2: v = 14999;
        default: v = 15000;
      endcase
    end else begin
      v = $urandom_range(0, 20000);
      v = v - 5000;
    end
    return i2c_hts_pkg::TempW'(v);
  endfunction

  // called just after an edge; returns just after the edge that took the word
  task automatic send_word(logic [1:0] f, logic [7:0] wb,
                           logic [i2c_hts_pkg::HumW-1:0] hum,
                           logic signed [i2c_hts_pkg::TempW-1:0] temp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i          <= 1'b1;
    func_i              <= f;
    write_byte_i        <= wb;
    humidity_centi_i    <= hum;
    temperature_centi_i <= temp;
    do @(posedge clk_i); while (in_stall_o);
    sensor_sb.note_word(f, wb, hum, temp);
    words_sent++;
  endtask

  task automatic send_measure(logic [i2c_hts_pkg::HumW-1:0] hum,
                              logic signed [i2c_hts_pkg::TempW-1:0] temp);
    send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte0, rand_hum(), rand_temp());
    send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte1, rand_hum(), rand_temp());
    send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte2, hum, temp);
  endtask

  task automatic send_reads(int unsigned count);
    repeat (count) send_word(i2c_hts_pkg::FuncRead, 8'($urandom), rand_hum(), rand_temp());
  endtask

  initial begin
    int unsigned pick;
    logic [7:0]  junk;
    bit          drained;
    drained = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no data yet, spare code, broken command, min and max codes,
    // retrigger mid-frame, ignored byte after the command, read past the frame
    send_reads(1);
    send_word(FuncSpare, 8'hFF, 14'h3FFF, -15'sd1);
    send_word(i2c_hts_pkg::FuncWrite, 8'h12, 14'd0, 15'sd0);
    send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte0, 14'd0, 15'sd0);
    send_word(i2c_hts_pkg::FuncWrite, 8'h34, 14'd0, 15'sd0);
    send_measure(14'd0, -15'sd5000);
    send_reads(2);
    send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte2, 14'd10000, 15'sd15000);
    send_reads(6);
    send_word(i2c_hts_pkg::FuncConnect, 8'h00, 14'd0, 15'sd0);
    send_measure(14'd5000, 15'sd2500);
    send_word(i2c_hts_pkg::FuncWrite, 8'hFF, 14'd0, 15'sd0);
    send_reads(7);
    send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte2, 14'd1234, -15'sd4321);
    send_reads(2);

    while (words_sent < WordTarget) begin
      if (!drained && words_sent > WordTarget / 2) begin
        // hold the sender off until every expected word is back
        drained = 1'b1;
        in_valid_i <= 1'b0;
        burst_left = 0;
        do @(posedge clk_i); while (sensor_sb.byte_q.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 4) != 0) begin
          send_word(i2c_hts_pkg::FuncConnect, 8'($urandom), rand_hum(), rand_temp());
        end
        send_measure(rand_hum(), rand_temp());
        send_reads($urandom_range(0, 9));
      end else if (pick < 70) begin
        send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte2, rand_hum(), rand_temp());
        send_reads($urandom_range(0, 8));
      end else if (pick < 80) begin
        send_word(i2c_hts_pkg::FuncWrite, i2c_hts_pkg::CmdByte0, rand_hum(), rand_temp());
        junk = 8'($urandom);
        if (junk == i2c_hts_pkg::CmdByte1) junk = ~junk;
        send_word(i2c_hts_pkg::FuncWrite, junk, rand_hum(), rand_temp());
        send_reads($urandom_range(0, 2));
      end else if (pick < 90) begin
        send_reads($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom), rand_hum(), rand_temp());
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sensor_sb.byte_q.size() != 0);
    repeat (10) @(posedge clk_i);
    if (sensor_sb.errors == 0) begin
      $display("i2c_humidity_temperature_sensor_core: match");
    end else begin
      $display("i2c_humidity_temperature_sensor_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/i2c_hts_pkg.sv
rtl/core/i2c_humidity_temperature_sensor_core.sv
test/i2c_humidity_temperature_sensor_core_tb.sv
